[rtl/particle_attractor_step_assert.svh]
// assertion macros for the particle attractor step block
// no dependencies; taken in by the top module, which checks its own logic
`ifndef PARTICLE_ATTRACTOR_STEP_ASSERT_SVH
`define PARTICLE_ATTRACTOR_STEP_ASSERT_SVH
`ifndef SYNTH
// checked property, off while reset is high
`define PAS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("particle attractor step: assertion failed");
// checked property, also during reset
`define PAS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("particle attractor step: assertion failed");
`else
`define PAS_ASSERT(label, clk, rst, prop)
`define PAS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/pas_pkg.sv]
// shared widths, register codes and attractor settings type
// no dependencies; used by pas_lane and the top module of the particle attractor step
`default_nettype none
package pas_pkg;

  localparam int FIELD_W  = 24;              // fixed point field width
  localparam int WIN_W    = 12;              // window bound width
  localparam int MAX_ATTR = 2;               // attractors in the register map
  localparam int DX_W     = FIELD_W + 1;     // attractor minus particle
  localparam int S2_W     = 2 * FIELD_W + 2; // squared distance
  localparam int SQ_W     = S2_W / 2;        // distance
  localparam int Q_W      = FIELD_W + 7;     // force magnitude, below 100 * 2^23
  localparam int P_W      = Q_W + DX_W;      // force times offset
  localparam int DV_W     = FIELD_W + 9;     // signed velocity change
  localparam int ADDR_W   = 5;

  typedef enum logic [2:0] {
    REG_ATTR0_X   = 3'd0,
    REG_ATTR0_Y   = 3'd1,
    REG_ATTR0_K   = 3'd2,
    REG_ATTR1_X   = 3'd3,
    REG_ATTR1_Y   = 3'd4,
    REG_ATTR1_K   = 3'd5,
    REG_WIN_W     = 3'd6,
    REG_WIN_H     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] k;
  } attr_cfg_t;

endpackage
`default_nettype wire

[rtl/pas_delay.sv]
// fixed-length delay line that advances on the pipeline enable
// depends on nothing but its parameters
`default_nettype none
module pas_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

[rtl/pas_div.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`default_nettype none
module pas_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] num_q [1:NUM_W-1];
  logic [DEN_W-1:0] den_q [1:NUM_W-1];
  logic [DEN_W-1:0] rem_q [1:NUM_W-1];
  logic [NUM_W-1:0] quo_q [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] n_in;
    logic [DEN_W-1:0] d_in;
    logic [DEN_W-1:0] r_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign n_in = num;
      assign d_in = den;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_rest
      assign n_in = num_q[k];
      assign d_in = den_q[k];
      assign r_in = rem_q[k];
      assign q_in = quo_q[k];
    end

    assign rem_sh = {r_in, n_in[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, d_in};
    assign take   = (rem_sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k+1] <= {q_in[NUM_W-2:0], take};
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_q[k+1] <= n_in << 1;
          den_q[k+1] <= d_in;
          rem_q[k+1] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
      end
    end
  end

  assign quo = quo_q[NUM_W];

endmodule
`default_nettype wire

[rtl/pas_isqrt.sv]
// pipelined integer square root, one root bit per stage (floor)
// depends on nothing but its parameters
`default_nettype none
module pas_isqrt #(
  parameter int RAD_W = 8
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [RAD_W-1:0]   rad,
  output logic      [RAD_W/2-1:0] root
);

  localparam int RT_W = RAD_W / 2;

  logic [RAD_W-1:0] rad_q  [1:RT_W-1];
  logic [RT_W+1:0]  rem_q  [1:RT_W-1];
  logic [RT_W-1:0]  root_q [1:RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic [RAD_W-1:0] a_in;
    logic [RT_W+1:0]  r_in;
    logic [RT_W-1:0]  t_in;
    logic [RT_W+3:0]  rem_sh;
    logic [RT_W+3:0]  trial;
    logic [RT_W+3:0]  diff;
    logic             take;

    if (k == 0) begin : g_first
      assign a_in = rad;
      assign r_in = '0;
      assign t_in = '0;
    end else begin : g_rest
      assign a_in = rad_q[k];
      assign r_in = rem_q[k];
      assign t_in = root_q[k];
    end

    // bring down the next bit pair, try root*4+1
    assign rem_sh = {r_in, a_in[RAD_W-1 -: 2]};
    assign trial  = (RT_W+4)'({t_in, 2'b01});
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k+1] <= {t_in[RT_W-2:0], take};
      end
    end

    if (k < RT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[k+1] <= a_in << 2;
          rem_q[k+1] <= take ? diff[RT_W+1:0] : rem_sh[RT_W+1:0];
        end
      end
    end
  end

  assign root = root_q[RT_W];

endmodule
`default_nettype wire

[rtl/pas_lane.sv]
// one attractor: offset, squared distance, root, force and velocity change
// depends on pas_pkg, pas_div, pas_isqrt and pas_delay
`default_nettype none
module pas_lane #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] pos_x,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] pos_y,
  input  wire pas_pkg::attr_cfg_t                 cfg,
  output logic signed      [pas_pkg::DV_W-1:0]    dv_x,
  output logic signed      [pas_pkg::DV_W-1:0]    dv_y
);
  import pas_pkg::*;

  localparam int NUM_W    = FIELD_W + 2 * FRAC_BITS;
  localparam int ROOT_LAT = S2_W / 2;
  // |d| > 0.1 is s2 > floor(2^2F / 100)
  localparam logic [S2_W-1:0] NEAR_LIM = S2_W'((64'd1 << (2 * FRAC_BITS)) / 100);
  localparam int SIDE_W = 2 * DX_W + 2;

  // offset
  logic signed [DX_W-1:0] dx1, dy1;
  // squares
  logic signed [S2_W-1:0] sqx2, sqy2;
  logic signed [DX_W-1:0] dx2, dy2;
  // squared distance
  logic [S2_W-1:0]        s2_c;
  logic [S2_W-1:0]        s2_3;
  logic signed [DX_W-1:0] dx3, dy3;
  logic [FIELD_W-1:0]     kmag3;
  logic                   kneg3, skip3;
  // divider and root outputs with aligned side data
  logic [NUM_W-1:0]       qq;
  logic [SQ_W-1:0]        root, root_d;
  logic [SIDE_W-1:0]      side_d;
  logic signed [DX_W-1:0] dxd, dyd;
  logic                   knegd, skipd;
  logic [DX_W-1:0]        adx, ady;
  // products
  logic [P_W-1:0]         pmx4, pmy4;
  logic [SQ_W-1:0]        s4;
  logic [2:0]             flag4, flag_d;
  logic [P_W-1:0]         qx, qy;
  logic [DV_W-1:0]        mx, my;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DX_W'(cfg.x) - DX_W'(pos_x);
      dy1 <= DX_W'(cfg.y) - DX_W'(pos_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= dx1 * dx1;
      sqy2 <= dy1 * dy1;
      dx2  <= dx1;
      dy2  <= dy1;
    end
  end

  assign s2_c = unsigned'(sqx2) + unsigned'(sqy2);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_3  <= s2_c;
      dx3   <= dx2;
      dy3   <= dy2;
      kneg3 <= cfg.k[FIELD_W-1];
      kmag3 <= cfg.k[FIELD_W-1] ? FIELD_W'(-cfg.k) : cfg.k;
      skip3 <= (s2_c <= NEAR_LIM);
    end
  end

  pas_div #(.NUM_W(NUM_W), .DEN_W(S2_W)) u_force (
    .clk (clk),
    .en  (en),
    .num (NUM_W'(kmag3) << (2 * FRAC_BITS)),
    .den (s2_3),
    .quo (qq)
  );

  pas_isqrt #(.RAD_W(S2_W)) u_root (
    .clk  (clk),
    .en   (en),
    .rad  (s2_3),
    .root (root)
  );

  pas_delay #(.WIDTH(SQ_W), .DEPTH(NUM_W - ROOT_LAT)) u_root_dly (
    .clk  (clk),
    .en   (en),
    .din  (root),
    .dout (root_d)
  );

  pas_delay #(.WIDTH(SIDE_W), .DEPTH(NUM_W)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  ({dx3, dy3, kneg3, skip3}),
    .dout (side_d)
  );

  assign {dxd, dyd, knegd, skipd} = side_d;
  assign adx = dxd[DX_W-1] ? DX_W'(-dxd) : dxd;
  assign ady = dyd[DX_W-1] ? DX_W'(-dyd) : dyd;

  always_ff @(posedge clk) begin
    if (en) begin
      pmx4  <= qq[Q_W-1:0] * adx;
      pmy4  <= qq[Q_W-1:0] * ady;
      s4    <= root_d;
      flag4 <= {knegd ^ dxd[DX_W-1], knegd ^ dyd[DX_W-1], skipd || (root_d == '0)};
    end
  end

  pas_div #(.NUM_W(P_W), .DEN_W(SQ_W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (pmx4),
    .den (s4),
    .quo (qx)
  );

  pas_div #(.NUM_W(P_W), .DEN_W(SQ_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (pmy4),
    .den (s4),
    .quo (qy)
  );

  pas_delay #(.WIDTH(3), .DEPTH(P_W)) u_flag_dly (
    .clk  (clk),
    .en   (en),
    .din  (flag4),
    .dout (flag_d)
  );

  assign mx = {1'b0, qx[DV_W-2:0]};
  assign my = {1'b0, qy[DV_W-2:0]};

  // truncation toward zero: divide magnitudes, then apply the sign
  always_ff @(posedge clk) begin
    if (en) begin
      if (flag_d[0]) begin
        dv_x <= '0;
        dv_y <= '0;
      end else begin
        dv_x <= flag_d[2] ? -signed'(mx) : signed'(mx);
        dv_y <= flag_d[1] ? -signed'(my) : signed'(my);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/particle_attractor_step.sv]
// Particle update pipeline: takes one particle (position, velocity) per cycle and
// returns it with velocity pulled by up to two inverse-square attractors, position
// advanced by the new velocity, both saturated, and a removed flag for positions
// outside the window. Throughput is one particle per cycle unless stalled. Each
// attractor lane holds pipelined dividers in series (force, then velocity change).
// A stalled output holds the whole pipeline. Registers sit on an APB port at 4*i.
// depends on pas_pkg, pas_lane, pas_delay and the assertion macro header
`default_nettype none
module particle_attractor_step #(
  parameter int NUM_ATTRACTORS = 2,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] pos_x,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] pos_y,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] vel_x,
  input  wire logic signed [pas_pkg::FIELD_W-1:0] vel_y,
  // output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [pas_pkg::FIELD_W-1:0] new_pos_x,
  output logic signed      [pas_pkg::FIELD_W-1:0] new_pos_y,
  output logic signed      [pas_pkg::FIELD_W-1:0] new_vel_x,
  output logic signed      [pas_pkg::FIELD_W-1:0] new_vel_y,
  output logic                                    removed,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pas_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import pas_pkg::*;

  localparam int NUM_W    = FIELD_W + 2 * FRAC_BITS;
  localparam int LANE_LAT = NUM_W + P_W + 5;
  localparam int SUM_W    = DV_W + 2;
  localparam int CMP_W    = ((FIELD_W > WIN_W + FRAC_BITS) ? FIELD_W : WIN_W + FRAC_BITS) + 1;
  localparam int PKT_W    = 4 * FIELD_W;

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(FIELD_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return FIELD_W'(hi);
    end else if (v < lo) begin
      return FIELD_W'(lo);
    end
    return FIELD_W'(v);
  endfunction

  // configuration registers
  attr_cfg_t        attr [0:MAX_ATTR-1];
  logic [WIN_W-1:0] win_w, win_h;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      attr[0] <= '{x: FIELD_W'(102400), y: FIELD_W'(76800), k: FIELD_W'(12800)};
      attr[1] <= '{x: FIELD_W'(51200), y: FIELD_W'(38400), k: -FIELD_W'(12800)};
      win_w   <= WIN_W'(800);
      win_h   <= WIN_W'(600);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTR0_X: attr[0].x <= pwdata[FIELD_W-1:0];
        REG_ATTR0_Y: attr[0].y <= pwdata[FIELD_W-1:0];
        REG_ATTR0_K: attr[0].k <= pwdata[FIELD_W-1:0];
        REG_ATTR1_X: attr[1].x <= pwdata[FIELD_W-1:0];
        REG_ATTR1_Y: attr[1].y <= pwdata[FIELD_W-1:0];
        REG_ATTR1_K: attr[1].k <= pwdata[FIELD_W-1:0];
        REG_WIN_W:   win_w     <= pwdata[WIN_W-1:0];
        REG_WIN_H:   win_h     <= pwdata[WIN_W-1:0];
        default:     win_h     <= win_h;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTR0_X: prdata = 32'(attr[0].x);
      REG_ATTR0_Y: prdata = 32'(attr[0].y);
      REG_ATTR0_K: prdata = 32'(attr[0].k);
      REG_ATTR1_X: prdata = 32'(attr[1].x);
      REG_ATTR1_Y: prdata = 32'(attr[1].y);
      REG_ATTR1_K: prdata = 32'(attr[1].k);
      REG_WIN_W:   prdata = 32'(win_w);
      REG_WIN_H:   prdata = 32'(win_h);
      default:     prdata = '0;
    endcase
  end

  // pipeline advances unless a finished result is held
  logic en;
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  // input stage
  logic                      v0;
  logic signed [FIELD_W-1:0] px0, py0, vx0, vy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0 <= pos_x;
      py0 <= pos_y;
      vx0 <= vel_x;
      vy0 <= vel_y;
    end
  end

  // attractor lanes
  logic signed [DV_W-1:0] dvx [0:MAX_ATTR-1];
  logic signed [DV_W-1:0] dvy [0:MAX_ATTR-1];

  for (genvar i = 0; i < MAX_ATTR; i++) begin : g_lane
    if (i < NUM_ATTRACTORS) begin : g_on
      pas_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk   (clk),
        .en    (en),
        .pos_x (px0),
        .pos_y (py0),
        .cfg   (attr[i]),
        .dv_x  (dvx[i]),
        .dv_y  (dvy[i])
      );
    end else begin : g_off
      assign dvx[i] = '0;
      assign dvy[i] = '0;
    end
  end

  // particle alongside the lanes
  logic [LANE_LAT-1:0]       vpipe;
  logic [PKT_W-1:0]          pkt_d;
  logic signed [FIELD_W-1:0] pxd, pyd, vxd, vyd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LANE_LAT-2:0], v0};
    end
  end

  pas_delay #(.WIDTH(PKT_W), .DEPTH(LANE_LAT)) u_pkt_dly (
    .clk  (clk),
    .en   (en),
    .din  ({px0, py0, vx0, vy0}),
    .dout (pkt_d)
  );

  assign {pxd, pyd, vxd, vyd} = pkt_d;

  // velocity sum, saturated once after all attractors
  logic                      vv;
  logic signed [FIELD_W-1:0] vnx, vny, pxv, pyv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= 1'b0;
    end else if (en) begin
      vv <= vpipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vnx <= sat_field(SUM_W'(vxd) + SUM_W'(dvx[0]) + SUM_W'(dvx[1]));
      vny <= sat_field(SUM_W'(vyd) + SUM_W'(dvy[0]) + SUM_W'(dvy[1]));
      pxv <= pxd;
      pyv <= pyd;
    end
  end

  // position step and window test
  logic signed [FIELD_W-1:0] npx, npy;
  logic signed [CMP_W-1:0]   npx_w, npy_w, bw, bh;

  assign npx   = sat_field(SUM_W'(pxv) + SUM_W'(vnx));
  assign npy   = sat_field(SUM_W'(pyv) + SUM_W'(vny));
  assign npx_w = CMP_W'(npx);
  assign npy_w = CMP_W'(npy);
  assign bw    = signed'(CMP_W'(win_w) << FRAC_BITS);
  assign bh    = signed'(CMP_W'(win_h) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_pos_x <= npx;
      new_pos_y <= npy;
      new_vel_x <= vnx;
      new_vel_y <= vny;
      removed   <= npx[FIELD_W-1] || npy[FIELD_W-1] || (npx_w > bw) || (npy_w > bh);
    end
  end

  `include "particle_attractor_step_assert.svh"

  // a negative position always lies outside the window
  `PAS_ASSERT(a_neg_removed, clk, rst,
    out_valid && (new_pos_x[FIELD_W-1] || new_pos_y[FIELD_W-1]) |-> removed)
  // back-pressure only comes from a held result
  `PAS_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid)
  // reset empties the pipeline
  `PAS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !vv)

endmodule
`default_nettype wire
